### hdl/lnu_pkg.sv
// Package for the layer normalization unit.
// Holds payload word types, field widths, status and register codes.
// No dependencies.
package lnu_pkg;

	localparam int VALUE_WIDTH = 24;
	localparam int INDEX_WIDTH = 10;
	localparam int COUNT_REG_WIDTH = 11;
	localparam int CFG_DATA_WIDTH = 32;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_INCOMPLETE = 2'd1,
		STATUS_RANGE      = 2'd2
	} status_t;

	typedef enum logic {
		REG_ELEMENT_COUNT = 1'b0,
		REG_EPSILON       = 1'b1
	} reg_index_t;

	localparam logic [COUNT_REG_WIDTH-1:0] ELEMENT_COUNT_RESET = 11'd768;
	localparam logic [CFG_DATA_WIDTH-1:0] EPSILON_RESET = 32'd168;

	typedef struct packed {
		kind_t                         kind;
		logic signed [VALUE_WIDTH-1:0] value;
		logic signed [VALUE_WIDTH-1:0] scale;
		logic signed [VALUE_WIDTH-1:0] shift;
		logic [INDEX_WIDTH-1:0]        index;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] normalized;
		status_t                       status;
	} out_word_t;

endpackage

### hdl/layer_normalization_unit.sv
// Layer normalization unit: vector store, shared restoring divider,
// digit-by-digit square root and read datapath.
// Depends on lnu_pkg.
//
// Usage: words enter on in_valid/in_stall and leave on out_valid/out_stall.
// A load word stores value, scale and shift at the next fill position and
// gives no result. The load that reaches element_count starts the statistics:
// a pass over the vector for the sum, a division for the mean, a second
// pass for the squared deviations, a division for the variance, a division
// for 2^64 / (variance + epsilon) and a 32-step square root. That load keeps
// the block busy until the statistics are done; every other load leaves the
// block idle, ready for the next word.
// A read word gives one result word: an error status (vector incomplete,
// index out of range) or a normalized value, the normalize chain being one
// multiplier step per cycle.
// in_stall is high while the sequencer works on a word. A finished result
// waits in the output register while out_stall is high; loads are still
// taken meanwhile, and a read waits in its last step for the register.
// Reset empties the vector and clears ready; the stores need no clearing.
// Configuration writes are taken in any cycle on cfg_we.
module layer_normalization_unit #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  lnu_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lnu_pkg::out_word_t                  out_data,
	input  logic                                cfg_we,
	input  lnu_pkg::reg_index_t                 cfg_index,
	input  logic [lnu_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import lnu_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int EW = CW + COUNT_REG_WIDTH;
	localparam int IW = CW + INDEX_WIDTH;
	localparam logic [EW-1:0] MAX_EW = EW'(MAX_ELEMENTS);
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_ELEMENTS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SUM   = 9'b000000010,
		ST_MEAN  = 9'b000000100,
		ST_VAR   = 9'b000001000,
		ST_VDIV  = 9'b000010000,
		ST_RECIP = 9'b000100000,
		ST_ROOT  = 9'b001000000,
		ST_READ  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [COUNT_REG_WIDTH-1:0] elem_count_q;
	logic [CFG_DATA_WIDTH-1:0]  epsilon_q;
	logic [CW-1:0]              fill_q;
	logic                       ready_q;
	logic signed [39:0]         mean_q;
	logic [31:0]                inv_dev_q;

	// vector stores
	logic [VALUE_WIDTH-1:0] act_mem [MAX_ELEMENTS];
	logic [VALUE_WIDTH-1:0] gain_mem [MAX_ELEMENTS];
	logic [VALUE_WIDTH-1:0] bias_mem [MAX_ELEMENTS];
	logic [VALUE_WIDTH-1:0] act_rd_q, gain_rd_q, bias_rd_q;
	logic [AW-1:0]          raddr, rd_addr_q, waddr;
	logic                   mem_we;

	// sequencer
	logic [CW-1:0]      cnt_q;
	logic               iss_s1, v_s2, v_s3;
	logic signed [29:0] d_s2;
	logic [57:0]        sq_s3;
	logic signed [36:0] sum_q;
	logic [70:0]        acc_q;
	logic [63:0]        tot_q;
	logic               launch_q;
	logic [2:0]         rstep_q;

	// read datapath
	logic [28:0]            dm_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] gmag_q;
	logic signed [VALUE_WIDTH-1:0] bias_q;
	logic [60:0]            prod_q;
	logic [27:0]            nrm_q;
	logic [30:0]            p_q;
	out_word_t              res_q;
	logic                   out_valid_q;
	out_word_t              out_data_q;

	// shared divider
	logic [64:0] dv_rem_q, dv_quo_q;
	logic [63:0] dv_den_q;
	logic [6:0]  dv_cnt_q;
	logic        dv_busy_q;
	logic        dv_start;
	logic [64:0] dv_num;
	logic [63:0] dv_div;
	logic [64:0] dv_sh;
	logic [65:0] dv_diff;
	logic        dv_fits;

	// square root
	logic [63:0] sq_src_q;
	logic [33:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic [5:0]  sq_cnt_q;
	logic [33:0] sq_sh, sq_trial;

	logic [CW-1:0]      n_eff;
	logic [EW-1:0]      ec_ext;
	logic               in_acc, load_acc, issue;
	logic [CW-1:0]      wptr, new_fill;
	logic [IW-1:0]      idx_ext;
	logic signed [40:0] d_wide;
	logic signed [29:0] d_calc;
	logic [29:0]        d_mag;
	logic [36:0]        sum_mag;
	logic [41:0]        mean_num;
	logic [61:0]        rnd;
	logic [52:0]        prod2;
	logic signed [33:0] y;
	logic               gneg;

	assign ec_ext = EW'(elem_count_q);
	always_comb begin
		if (elem_count_q == '0) begin
			n_eff = CW'(1);
		end else if (ec_ext > MAX_EW) begin
			n_eff = MAX_CW;
		end else begin
			n_eff = ec_ext[CW-1:0];
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && (state_q == ST_IDLE);
	assign load_acc = in_acc && (in_data.kind == KIND_LOAD);
	assign issue = ((state_q == ST_SUM) || (state_q == ST_VAR)) && (cnt_q < n_eff);
	assign raddr = ((state_q == ST_SUM) || (state_q == ST_VAR)) ? cnt_q[AW-1:0] : rd_addr_q;

	always_comb begin
		wptr = ready_q ? '0 : fill_q;
		if (wptr >= MAX_CW) begin
			wptr = '0;
		end
	end
	assign new_fill = wptr + CW'(1);
	assign waddr = wptr[AW-1:0];
	assign mem_we = load_acc;
	assign idx_ext = IW'(in_data.index);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			act_mem[waddr] <= in_data.value;
			gain_mem[waddr] <= in_data.scale;
			bias_mem[waddr] <= in_data.shift;
		end
		act_rd_q <= act_mem[raddr];
		gain_rd_q <= gain_mem[raddr];
		bias_rd_q <= bias_mem[raddr];
	end

	// deviation of the word just read from the mean, Q.4
	assign d_wide = $signed({{13{act_rd_q[VALUE_WIDTH-1]}}, act_rd_q, 4'b0})
		- $signed({mean_q[39], mean_q});
	assign d_calc = d_wide[29:0];
	assign d_mag = d_s2[29] ? 30'(-d_s2) : 30'(d_s2);
	assign sum_mag = sum_q[36] ? 37'(-sum_q) : 37'(sum_q);
	assign mean_num = {1'b0, sum_mag, 4'b0} + 42'(n_eff >> 1);
	assign gneg = gain_rd_q[VALUE_WIDTH-1];

	// divider operand select
	always_comb begin
		dv_start = 1'b0;
		dv_num = '0;
		dv_div = 64'(n_eff);
		case (state_q)
			ST_MEAN: begin
				dv_start = !launch_q;
				dv_num = 65'(mean_num);
			end
			ST_VDIV: begin
				dv_start = !launch_q;
				dv_num = 65'(acc_q[70:8]);
			end
			ST_RECIP: begin
				dv_start = !launch_q && (tot_q > 64'd1);
				dv_num = {1'b1, 64'b0};
				dv_div = tot_q;
			end
			default: begin
				dv_start = 1'b0;
			end
		endcase
	end

	assign dv_sh = {dv_rem_q[63:0], dv_quo_q[64]};
	assign dv_diff = {1'b0, dv_sh} - {2'b0, dv_den_q};
	assign dv_fits = !dv_diff[65];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q <= '0;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
			dv_den_q <= '0;
		end else if (dv_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q <= 7'd65;
			dv_rem_q <= '0;
			dv_quo_q <= dv_num;
			dv_den_q <= dv_div;
		end else if (dv_busy_q) begin
			dv_rem_q <= dv_fits ? dv_diff[64:0] : dv_sh;
			dv_quo_q <= {dv_quo_q[63:0], dv_fits};
			dv_cnt_q <= dv_cnt_q - 7'd1;
			if (dv_cnt_q == 7'd1) begin
				dv_busy_q <= 1'b0;
			end
		end
	end

	assign sq_sh = {sq_rem_q[31:0], sq_src_q[63:62]};
	assign sq_trial = {sq_root_q, 2'b01};
	assign rnd = {1'b0, prod_q} + 62'd32768;
	assign prod2 = 53'(nrm_q * gmag_q) + 53'd524288;
	assign y = (neg_q ? -$signed({3'b0, p_q}) : $signed({3'b0, p_q}))
		+ 34'(bias_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_count_q <= ELEMENT_COUNT_RESET;
			epsilon_q <= EPSILON_RESET;
			fill_q <= '0;
			ready_q <= 1'b0;
			mean_q <= '0;
			inv_dev_q <= '0;
			cnt_q <= '0;
			iss_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			d_s2 <= '0;
			sq_s3 <= '0;
			sum_q <= '0;
			acc_q <= '0;
			tot_q <= '0;
			launch_q <= 1'b0;
			rstep_q <= '0;
			rd_addr_q <= '0;
			dm_q <= '0;
			neg_q <= 1'b0;
			gmag_q <= '0;
			bias_q <= '0;
			prod_q <= '0;
			nrm_q <= '0;
			p_q <= '0;
			res_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			sq_src_q <= '0;
			sq_rem_q <= '0;
			sq_root_q <= '0;
			sq_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ELEMENT_COUNT: elem_count_q <= cfg_data[COUNT_REG_WIDTH-1:0];
					REG_EPSILON:       epsilon_q <= cfg_data;
					default:           epsilon_q <= epsilon_q;
				endcase
			end
			// drop the taken word unless a new one moves in this cycle
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			// pass pipelines
			iss_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			v_s2 <= iss_s1 && (state_q == ST_VAR);
			d_s2 <= d_calc;
			v_s3 <= v_s2;
			sq_s3 <= 58'(d_mag[28:0] * d_mag[28:0]);

			case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						ready_q <= 1'b0;
						fill_q <= new_fill;
						if (new_fill >= n_eff) begin
							state_q <= ST_SUM;
							cnt_q <= '0;
							sum_q <= '0;
						end
					end else if (in_acc) begin
						if (!ready_q) begin
							res_q <= '{normalized: '0, status: STATUS_INCOMPLETE};
							state_q <= ST_OUT;
						end else if (idx_ext >= IW'(fill_q)) begin
							res_q <= '{normalized: '0, status: STATUS_RANGE};
							state_q <= ST_OUT;
						end else begin
							rd_addr_q <= idx_ext[AW-1:0];
							rstep_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_SUM: begin
					if (iss_s1) begin
						sum_q <= sum_q + 37'(signed'(act_rd_q));
					end
					if (!issue && !iss_s1) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (dv_start) begin
						launch_q <= 1'b1;
					end else if (!dv_busy_q) begin
						launch_q <= 1'b0;
						mean_q <= sum_q[36] ? -$signed(dv_quo_q[39:0])
							: $signed(dv_quo_q[39:0]);
						cnt_q <= '0;
						acc_q <= '0;
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (v_s3) begin
						acc_q <= acc_q + 71'(sq_s3);
					end
					if (!issue && !iss_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (dv_start) begin
						launch_q <= 1'b1;
					end else if (!dv_busy_q) begin
						launch_q <= 1'b0;
						tot_q <= dv_quo_q[63:0] + 64'(epsilon_q);
						state_q <= ST_RECIP;
					end
				end
				ST_RECIP: begin
					if (!launch_q && (tot_q <= 64'd1)) begin
						inv_dev_q <= '1;
						ready_q <= 1'b1;
						fill_q <= n_eff;
						state_q <= ST_IDLE;
					end else if (dv_start) begin
						launch_q <= 1'b1;
					end else if (!dv_busy_q) begin
						launch_q <= 1'b0;
						sq_src_q <= dv_quo_q[63:0];
						sq_rem_q <= '0;
						sq_root_q <= '0;
						sq_cnt_q <= 6'd32;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_cnt_q == '0) begin
						inv_dev_q <= sq_root_q;
						ready_q <= 1'b1;
						fill_q <= n_eff;
						state_q <= ST_IDLE;
					end else begin
						if (sq_sh >= sq_trial) begin
							sq_rem_q <= sq_sh - sq_trial;
							sq_root_q <= {sq_root_q[30:0], 1'b1};
						end else begin
							sq_rem_q <= sq_sh;
							sq_root_q <= {sq_root_q[30:0], 1'b0};
						end
						sq_src_q <= {sq_src_q[61:0], 2'b00};
						sq_cnt_q <= sq_cnt_q - 6'd1;
					end
				end
				ST_READ: begin
					rstep_q <= rstep_q + 3'd1;
					case (rstep_q)
						3'd1: begin
							dm_q <= d_calc[29] ? 29'(-d_calc) : 29'(d_calc);
							neg_q <= d_calc[29] != gneg;
							gmag_q <= gneg ? VALUE_WIDTH'(-gain_rd_q) : gain_rd_q;
							bias_q <= bias_rd_q;
						end
						3'd2: prod_q <= 61'(dm_q * inv_dev_q);
						3'd3: nrm_q <= (rnd[61:16] > 46'(28'h8000000)) ? 28'h8000000
							: rnd[43:16];
						3'd4: p_q <= prod2[50:20];
						3'd5: begin
							if (y > 34'sd8388607) begin
								res_q.normalized <= 24'sh7FFFFF;
							end else if (y < -34'sd8388608) begin
								res_q.normalized <= 24'sh800000;
							end else begin
								res_q.normalized <= y[VALUE_WIDTH-1:0];
							end
							res_q.status <= STATUS_OK;
							state_q <= ST_OUT;
						end
						default: begin
						end
					endcase
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_data_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_ready_has_vector: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (fill_q != '0))
		else $error("ready with empty vector");

	a_load_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !ready_q)
		else $error("load did not clear ready");

	a_div_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		dv_busy_q |-> (state_q == ST_MEAN || state_q == ST_VDIV || state_q == ST_RECIP))
		else $error("divider busy outside its states");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result without read");

endmodule
